// ----- sv/dwsg_pkg.sv -----
// Shared types, register indexes and the cosine table generator for the DAC sample generator.
package dwsg_pkg;

   typedef enum logic [1:0] {
      MODE_CONST  = 2'd0,
      MODE_SINE   = 2'd1,
      MODE_SQUARE = 2'd2,
      MODE_MSEQ   = 2'd3
   } wave_mode_type;

   typedef enum logic [2:0] {
      CSR_WAVE_MODE       = 3'd0,
      CSR_PHASE_STEP      = 3'd1,
      CSR_LEVEL_HIGH      = 3'd2,
      CSR_LEVEL_LOW       = 3'd3,
      CSR_OFFSET_BINARY   = 3'd4,
      CSR_SEQ_SEED        = 3'd5,
      CSR_SEQ_RATIO       = 3'd6,
      CSR_SEQ_START_DELAY = 3'd7
   } csr_index_type;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 10;
   localparam logic [31:0] SEED_RESET = 32'd1;

   typedef struct packed {
      logic          valid;
      wave_mode_type mode;
      logic          negate;
      logic          zero;
      logic [15:0]   level_code;
      logic          seq_bit;
   } sample_meta_type;

   // Quarter-wave cosine in Q1.15, Taylor series in Q30, rounded half up
   function automatic logic [15:0] cos_entry(int unsigned index, int unsigned table_bits);
      longint unsigned y;
      longint unsigned y2;
      longint unsigned term;
      longint unsigned q;
      longint          acc;
      y = (HALF_PI_Q30 * 64'(index)) >> table_bits;
      y2 = (y * y) >> 30;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * y2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = (unsigned'(acc) + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return 16'(q);
   endfunction

endpackage

// ----- sv/dwsg_cos_rom.sv -----
// Quarter-wave cosine ROM with registered read.
module dwsg_cos_rom #(
   parameter int TABLE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [TABLE_BITS-1:0] rd_addr,
   output logic [15:0]           rd_data
);
   import dwsg_pkg::*;

   localparam int QUARTER_LEN = 1 << TABLE_BITS;

   logic [15:0] rom [QUARTER_LEN];
   logic [15:0] rd_data_ff;

   for (genvar g = 0; g < QUARTER_LEN; g++) begin : g_rom
      assign rom[g] = cos_entry(g, TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dwsg_ctrl.sv -----
// Generator state: phase accumulator, start delay and LFSR, updated once per transaction.
module dwsg_ctrl #(
   parameter int TABLE_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      accept,
   input  logic                      restart,
   input  dwsg_pkg::wave_mode_type   wave_mode,
   input  logic [31:0]               phase_step,
   input  logic [15:0]               level_high,
   input  logic [15:0]               level_low,
   input  logic [31:0]               seq_seed,
   input  logic [15:0]               seq_ratio,
   input  logic [15:0]               seq_start_delay,
   output dwsg_pkg::sample_meta_type meta,
   output logic [TABLE_BITS-1:0]     rom_addr
);
   import dwsg_pkg::*;

   logic [31:0] phase_ff, phase_in;
   logic [31:0] shift_ff, shift_in;
   logic        prev_top_ff, prev_top_in;
   logic        out_bit_ff, out_bit_in;
   logic [16:0] hold_ff, hold_in;
   logic [15:0] delay_ff, delay_in;

   logic [31:0] eff_phase;
   logic [31:0] eff_shift;
   logic        eff_prev_top;
   logic        eff_out_bit;
   logic [16:0] eff_hold;
   logic [15:0] eff_delay;
   logic [16:0] hold_dec;
   logic [15:0] code;
   logic [TABLE_BITS-1:0] idx;
   logic [TABLE_BITS-1:0] addr_in;
   logic        negate_in, zero_in;

   sample_meta_type       meta_ff, meta_in;
   logic [TABLE_BITS-1:0] addr_ff;

   always_comb begin
      eff_phase    = restart ? 32'd0 : phase_ff;
      eff_shift    = restart ? seq_seed : shift_ff;
      eff_prev_top = restart ? 1'b0 : prev_top_ff;
      eff_out_bit  = restart ? 1'b1 : out_bit_ff;
      eff_hold     = restart ? 17'd1 : hold_ff;
      eff_delay    = restart ? seq_start_delay : delay_ff;
      hold_dec     = eff_hold - 17'd1;

      phase_in    = eff_phase;
      shift_in    = eff_shift;
      prev_top_in = eff_prev_top;
      out_bit_in  = eff_out_bit;
      hold_in     = eff_hold;
      delay_in    = eff_delay;
      code        = level_high;

      unique case (wave_mode)
         MODE_SINE: begin
            phase_in = eff_phase + phase_step;
         end
         MODE_SQUARE: begin
            phase_in = eff_phase + phase_step;
            code = eff_phase[31] ? level_high : level_low;
         end
         MODE_MSEQ: begin
            if (eff_delay != 16'd0) begin
               delay_in = eff_delay - 16'd1;
               code = 16'd0;
            end else begin
               hold_in = hold_dec;
               if (hold_dec == 17'd0) begin
                  hold_in     = {1'b0, seq_ratio} + 17'd1;
                  out_bit_in  = eff_shift[12] ^ eff_prev_top;
                  prev_top_in = eff_shift[31];
                  shift_in    = {eff_shift[30:0], out_bit_in};
               end
               code = out_bit_in ? level_high : level_low;
            end
         end
         MODE_CONST: begin
            code = level_high;
         end
      endcase

      idx       = eff_phase[29 -: TABLE_BITS];
      addr_in   = eff_phase[30] ? (~idx + 1'b1) : idx;
      zero_in   = eff_phase[30] && (idx == '0);
      negate_in = eff_phase[31] ^ eff_phase[30];

      meta_in.valid      = accept;
      meta_in.mode       = wave_mode;
      meta_in.negate     = negate_in;
      meta_in.zero       = zero_in;
      meta_in.level_code = code;
      meta_in.seq_bit    = out_bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 32'd0;
         shift_ff    <= SEED_RESET;
         prev_top_ff <= 1'b0;
         out_bit_ff  <= 1'b1;
         hold_ff     <= 17'd1;
         delay_ff    <= 16'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         shift_ff    <= shift_in;
         prev_top_ff <= prev_top_in;
         out_bit_ff  <= out_bit_in;
         hold_ff     <= hold_in;
         delay_ff    <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (adv) begin
         meta_ff.valid <= meta_in.valid;
      end
      if (adv) begin
         meta_ff.mode       <= meta_in.mode;
         meta_ff.negate     <= meta_in.negate;
         meta_ff.zero       <= meta_in.zero;
         meta_ff.level_code <= meta_in.level_code;
         meta_ff.seq_bit    <= meta_in.seq_bit;
         addr_ff            <= addr_in;
      end
   end

   assign meta     = meta_ff;
   assign rom_addr = addr_ff;

endmodule

// ----- sv/dwsg_scale.sv -----
// Sine pipeline: sign table value, multiply by span, offset, saturate; else level code; convert.
module dwsg_scale #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  dwsg_pkg::sample_meta_type meta_s1,
   input  logic [15:0]               rom_data,
   input  logic [15:0]               level_high,
   input  logic [15:0]               level_low,
   input  logic                      offset_binary,
   output logic                      result_valid,
   output logic [15:0]               result_code,
   output logic                      result_seq_bit
);
   import dwsg_pkg::*;

   localparam logic signed [18:0] CODE_MAX = 19'sd1 <<< (SAMPLE_BITS - 1);
   localparam logic signed [18:0] CODE_TOP = CODE_MAX - 19'sd1;
   localparam logic signed [18:0] CODE_BOT = -CODE_MAX;
   localparam logic [15:0] SIGN_BIT = 16'd1 << (SAMPLE_BITS - 1);
   localparam logic [15:0] CODE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

   sample_meta_type     meta_s2_ff;
   sample_meta_type     meta_s3_ff;
   logic signed [33:0]  prod_ff, prod_in;
   logic signed [16:0]  cval;
   logic signed [16:0]  span;
   logic signed [16:0]  mid;
   logic signed [34:0]  sum;
   logic signed [18:0]  scaled;
   logic signed [18:0]  sat;
   logic [15:0]         code;

   always_comb begin
      if (meta_s2_ff.zero) begin
         cval = 17'sd0;
      end else if (meta_s2_ff.negate) begin
         cval = -$signed({1'b0, rom_data});
      end else begin
         cval = $signed({1'b0, rom_data});
      end
      span    = $signed({level_high[15], level_high}) - $signed({level_low[15], level_low});
      prod_in = cval * span;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_s2_ff.valid <= 1'b0;
         meta_s3_ff.valid <= 1'b0;
      end else if (adv) begin
         meta_s2_ff.valid <= meta_s1.valid;
         meta_s3_ff.valid <= meta_s2_ff.valid;
      end
      if (adv) begin
         meta_s2_ff.mode       <= meta_s1.mode;
         meta_s2_ff.negate     <= meta_s1.negate;
         meta_s2_ff.zero       <= meta_s1.zero;
         meta_s2_ff.level_code <= meta_s1.level_code;
         meta_s2_ff.seq_bit    <= meta_s1.seq_bit;
         meta_s3_ff.mode       <= meta_s2_ff.mode;
         meta_s3_ff.negate     <= meta_s2_ff.negate;
         meta_s3_ff.zero       <= meta_s2_ff.zero;
         meta_s3_ff.level_code <= meta_s2_ff.level_code;
         meta_s3_ff.seq_bit    <= meta_s2_ff.seq_bit;
         prod_ff               <= prod_in;
      end
   end

   always_comb begin
      mid    = $signed({level_high[15], level_high}) + $signed({level_low[15], level_low});
      sum    = 35'(prod_ff) + (35'(mid) <<< 15);
      scaled = 19'(sum >>> 16);
      if (scaled > CODE_TOP) begin
         sat = CODE_TOP;
      end else if (scaled < CODE_BOT) begin
         sat = CODE_BOT;
      end else begin
         sat = scaled;
      end
      code = (meta_s3_ff.mode == MODE_SINE) ? 16'(sat) : meta_s3_ff.level_code;
      if (offset_binary) begin
         code = (code ^ SIGN_BIT) & CODE_MASK;
      end
   end

   assign result_valid   = meta_s3_ff.valid;
   assign result_code    = code;
   assign result_seq_bit = meta_s3_ff.seq_bit;

endmodule

// ----- sv/dac_waveform_sample_generator_core.sv -----
// Top level of the DAC waveform sample generator: configuration registers, pipeline and output register.
// One request transaction is one sample tick and yields one response transaction holding a DAC
// code and the current m-sequence bit. A new request is taken every cycle unless a response waits
// on rsp_ready; rsp_valid is set through the stage registers in order (state update at the
// accepting edge, then cosine ROM read, span multiply and output register), and the whole pipeline
// holds while a response waits on rsp_ready.
// Configuration registers are written by csr_we/csr_index/csr_wdata and must only change
// while no transaction is in flight.
module dac_waveform_sample_generator_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int TABLE_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_sample_code,
   output logic                                rsp_seq_bit,
   input  logic                                csr_we,
   input  logic [dwsg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dwsg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import dwsg_pkg::*;

   wave_mode_type wave_mode_ff;
   logic [31:0]   phase_step_ff;
   logic [15:0]   level_high_ff;
   logic [15:0]   level_low_ff;
   logic          offset_binary_ff;
   logic [31:0]   seq_seed_ff;
   logic [15:0]   seq_ratio_ff;
   logic [15:0]   seq_start_delay_ff;

   logic            adv;
   logic            accept;
   sample_meta_type meta_s1;
   logic [TABLE_BITS-1:0] rom_addr;
   logic [15:0]     rom_data;
   logic            result_valid;
   logic [15:0]     result_code;
   logic            result_seq_bit;

   logic            rsp_valid_ff;
   logic [15:0]     rsp_code_ff;
   logic            rsp_seq_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff       <= MODE_CONST;
         phase_step_ff      <= 32'd0;
         level_high_ff      <= 16'd0;
         level_low_ff       <= 16'd0;
         offset_binary_ff   <= 1'b0;
         seq_seed_ff        <= SEED_RESET;
         seq_ratio_ff       <= 16'd0;
         seq_start_delay_ff <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAVE_MODE:       wave_mode_ff       <= wave_mode_type'(csr_wdata[1:0]);
            CSR_PHASE_STEP:      phase_step_ff      <= csr_wdata[31:0];
            CSR_LEVEL_HIGH:      level_high_ff      <= csr_wdata[15:0];
            CSR_LEVEL_LOW:       level_low_ff       <= csr_wdata[15:0];
            CSR_OFFSET_BINARY:   offset_binary_ff   <= csr_wdata[0];
            CSR_SEQ_SEED:        seq_seed_ff        <= csr_wdata[31:0];
            CSR_SEQ_RATIO:       seq_ratio_ff       <= csr_wdata[15:0];
            CSR_SEQ_START_DELAY: seq_start_delay_ff <= csr_wdata[15:0];
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   dwsg_ctrl #(
      .TABLE_BITS(TABLE_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .accept          (accept),
      .restart         (req_restart),
      .wave_mode       (wave_mode_ff),
      .phase_step      (phase_step_ff),
      .level_high      (level_high_ff),
      .level_low       (level_low_ff),
      .seq_seed        (seq_seed_ff),
      .seq_ratio       (seq_ratio_ff),
      .seq_start_delay (seq_start_delay_ff),
      .meta            (meta_s1),
      .rom_addr        (rom_addr)
   );

   dwsg_cos_rom #(
      .TABLE_BITS(TABLE_BITS)
   ) u_cos_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   dwsg_scale #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .meta_s1        (meta_s1),
      .rom_data       (rom_data),
      .level_high     (level_high_ff),
      .level_low      (level_low_ff),
      .offset_binary  (offset_binary_ff),
      .result_valid   (result_valid),
      .result_code    (result_code),
      .result_seq_bit (result_seq_bit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && result_valid) begin
         rsp_code_ff    <= result_code;
         rsp_seq_bit_ff <= result_seq_bit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_code = rsp_code_ff;
   assign rsp_seq_bit     = rsp_seq_bit_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the DAC waveform sample generator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
   import dwsg_pkg::*;

   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int STALL_LIMIT = 5000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      wave_mode_type mode;
      logic [31:0]   step;
      logic [15:0]   high;
      logic [15:0]   low;
      logic          offset_bin;
      logic [31:0]   seed;
      logic [15:0]   ratio;
      logic [15:0]   delay;
   } gen_cfg_type;

   typedef struct packed {
      logic        reconfig;
      gen_cfg_type cfg;
      logic        restart;
      logic        fixed;
      logic [15:0] code;
   } tick_row_type;

   typedef struct packed {
      logic [15:0] code;
      logic        seq_bit;
   } dac_sample_type;

   localparam gen_cfg_type RESET_CFG   = '{MODE_CONST, 32'd0, 16'h0000, 16'h0000, 1'b0,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_TOP       = '{MODE_CONST, 32'd0, 16'h7FFF, 16'h8000, 1'b0,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_BOT_OB    = '{MODE_CONST, 32'd0, 16'h8000, 16'h7FFF, 1'b1,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_TOP_OB    = '{MODE_CONST, 32'd0, 16'h7FFF, 16'h8000, 1'b1,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_SINE      = '{MODE_SINE, 32'h2000_0000, 16'h7FFF, 16'h8000, 1'b0,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_SINE_INV  = '{MODE_SINE, 32'h8000_0000, 16'h8000, 16'h7FFF, 1'b1,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_SQUARE    = '{MODE_SQUARE, 32'h8000_0000, 16'h04D2, 16'hFFFB, 1'b0,
                                           32'd1, 16'd0, 16'd0};
   localparam gen_cfg_type C_MSEQ      = '{MODE_MSEQ, 32'd0, 16'd100, 16'hFF9C, 1'b0,
                                           32'd1, 16'd0, 16'd2};
   localparam gen_cfg_type C_MSEQ_OB   = '{MODE_MSEQ, 32'd0, 16'h7FFF, 16'h8000, 1'b1,
                                           32'hFFFF_FFFF, 16'd1, 16'd1};
   localparam gen_cfg_type C_CONST_NEG = '{MODE_CONST, 32'd0, 16'hFFFF, 16'h0000, 1'b0,
                                           32'd1, 16'd0, 16'd0};

   localparam int DIRECTED_COUNT = 22;
   localparam tick_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{1'b0, RESET_CFG,   1'b0, 1'b1, 16'h0000},
      '{1'b1, C_TOP,       1'b0, 1'b1, 16'h7FFF},
      '{1'b1, C_BOT_OB,    1'b0, 1'b1, 16'h0000},
      '{1'b1, C_TOP_OB,    1'b0, 1'b1, 16'hFFFF},
      '{1'b1, C_SINE,      1'b1, 1'b0, 16'h0000},
      '{1'b0, C_SINE,      1'b0, 1'b0, 16'h0000},
      '{1'b0, C_SINE,      1'b0, 1'b0, 16'h0000},
      '{1'b0, C_SINE,      1'b0, 1'b0, 16'h0000},
      '{1'b0, C_SINE,      1'b0, 1'b0, 16'h0000},
      '{1'b0, C_SINE,      1'b0, 1'b0, 16'h0000},
      '{1'b1, C_SINE_INV,  1'b1, 1'b0, 16'h0000},
      '{1'b0, C_SINE_INV,  1'b0, 1'b0, 16'h0000},
      '{1'b1, C_SQUARE,    1'b1, 1'b1, 16'hFFFB},
      '{1'b0, C_SQUARE,    1'b0, 1'b1, 16'h04D2},
      '{1'b1, C_MSEQ,      1'b1, 1'b1, 16'h0000},
      '{1'b0, C_MSEQ,      1'b0, 1'b1, 16'h0000},
      '{1'b0, C_MSEQ,      1'b0, 1'b0, 16'h0000},
      '{1'b0, C_MSEQ,      1'b0, 1'b0, 16'h0000},
      '{1'b1, C_MSEQ_OB,   1'b1, 1'b1, 16'h8000},
      '{1'b0, C_MSEQ_OB,   1'b0, 1'b0, 16'h0000},
      '{1'b0, C_MSEQ_OB,   1'b1, 1'b1, 16'h8000},
      '{1'b1, C_CONST_NEG, 1'b1, 1'b1, 16'hFFFF}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sample_code;
   logic        rsp_seq_bit;
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   gen_cfg_type active_cfg = RESET_CFG;
   logic [15:0] cos_rom [256];
   logic [31:0] phase_acc;
   logic [31:0] lfsr;
   logic        lfsr_top_prev;
   logic        seq_out;
   logic [16:0] hold_left;
   logic [15:0] delay_left;

   dac_sample_type pending_samples [$];
   int          mismatches = 0;
   int          samples_checked = 0;
   int          ticks_sent = 0;
   int          settings_loaded = 0;
   int          quiet_cycles = 0;
   int          hold_off_left = 0;
   bit          hold_off_armed = 1'b0;
   bit          steady_run = 1'b0;

   dac_waveform_sample_generator_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_code (rsp_sample_code),
      .rsp_seq_bit     (rsp_seq_bit),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] quarter_cos(input int unsigned i);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned rounded;
      longint          sum;
      angle = (QUARTER_TURN_Q30 * 64'(i)) >> 8;
      angle_sq = (angle * angle) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int k = 1; k <= 10; k++) begin
         term = ((term * angle_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rounded = (64'(sum) + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[15:0];
   endfunction

   function automatic dac_sample_type next_sample(input logic restart);
      dac_sample_type s;
      logic [7:0]  idx;
      longint      c;
      longint      mirror;
      longint      v;
      longint      r;
      logic [15:0] level;
      if (restart) begin
         phase_acc = '0;
         lfsr = active_cfg.seed;
         seq_out = 1'b1;
         lfsr_top_prev = 1'b0;
         hold_left = 17'd1;
         delay_left = active_cfg.delay;
      end
      case (active_cfg.mode)
         MODE_SINE: begin
            idx = phase_acc[29:22];
            mirror = (idx == 8'd0) ? 0 : longint'(cos_rom[256 - int'(idx)]);
            case (phase_acc[31:30])
               2'd0: c = longint'(cos_rom[idx]);
               2'd1: c = -mirror;
               2'd2: c = -longint'(cos_rom[idx]);
               default: c = mirror;
            endcase
            v = c * (longint'($signed(active_cfg.high)) - longint'($signed(active_cfg.low)))
                + (longint'($signed(active_cfg.high)) + longint'($signed(active_cfg.low))) * 32768;
            r = v >>> 16;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            level = r[15:0];
            phase_acc = phase_acc + active_cfg.step;
         end
         MODE_SQUARE: begin
            level = phase_acc[31] ? active_cfg.high : active_cfg.low;
            phase_acc = phase_acc + active_cfg.step;
         end
         MODE_MSEQ: begin
            if (delay_left != 16'd0) begin
               delay_left = delay_left - 16'd1;
               level = 16'h0000;
            end else begin
               hold_left = hold_left - 17'd1;
               if (hold_left == 17'd0) begin
                  hold_left = {1'b0, active_cfg.ratio} + 17'd1;
                  seq_out = lfsr[12] ^ lfsr_top_prev;
                  lfsr_top_prev = lfsr[31];
                  lfsr = {lfsr[30:0], seq_out};
               end
               level = seq_out ? active_cfg.high : active_cfg.low;
            end
         end
         default: level = active_cfg.high;
      endcase
      s.code = active_cfg.offset_bin ? (level ^ 16'h8000) : level;
      s.seq_bit = seq_out;
      return s;
   endfunction

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic gen_cfg_type random_setting();
      gen_cfg_type c;
      c.mode = wave_mode_type'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0: c.step = 32'd0;
         1: c.step = 32'h8000_0000;
         2: c.step = $urandom_range(1, 32'h00FF_FFFF);
         default: c.step = $urandom_range(0, 32'h8000_0000);
      endcase
      c.high = pick_level();
      c.low = pick_level();
      c.offset_bin = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: c.seed = 32'd0;
         1: c.seed = 32'hFFFF_FFFF;
         default: c.seed = $urandom;
      endcase
      c.ratio = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      c.delay = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 200))
                                             : 16'($urandom_range(0, 6));
      return c;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_generator(input gen_cfg_type c);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      write_reg(CSR_WAVE_MODE, {30'd0, c.mode});
      write_reg(CSR_PHASE_STEP, c.step);
      write_reg(CSR_LEVEL_HIGH, {16'd0, c.high});
      write_reg(CSR_LEVEL_LOW, {16'd0, c.low});
      write_reg(CSR_OFFSET_BINARY, {31'd0, c.offset_bin});
      write_reg(CSR_SEQ_SEED, c.seed);
      write_reg(CSR_SEQ_RATIO, {16'd0, c.ratio});
      write_reg(CSR_SEQ_START_DELAY, {16'd0, c.delay});
      csr_we <= 1'b0;
      active_cfg = c;
      settings_loaded++;
   endtask

   task automatic push_tick(input logic restart, input logic fixed, input logic [15:0] code);
      dac_sample_type s;
      while (!steady_run && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      s = next_sample(restart);
      if (fixed) s.code = code;
      pending_samples.push_back(s);
      ticks_sent++;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch on response %0d: %s expected %h got %h",
                  samples_checked, what, want, got);
      end
   endtask

   task automatic check_sample();
      dac_sample_type want;
      if (pending_samples.size() == 0) begin
         report_mismatch("response with no pending transaction", 16'h0000, rsp_sample_code);
      end else begin
         want = pending_samples.pop_front();
         if (rsp_sample_code !== want.code) begin
            report_mismatch("sample_code", want.code, rsp_sample_code);
         end
         if (rsp_seq_bit !== want.seq_bit) begin
            report_mismatch("seq_bit", {15'd0, want.seq_bit}, {15'd0, rsp_seq_bit});
         end
      end
      samples_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_sample();
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_off_left = 80;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_run || ($urandom_range(0, 99) >= 27);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int n;
      gen_cfg_type cfg;
      for (int i = 0; i < 256; i++) cos_rom[i] = quarter_cos(i);
      phase_acc = '0;
      lfsr = 32'd1;
      lfsr_top_prev = 1'b0;
      seq_out = 1'b1;
      hold_left = 17'd1;
      delay_left = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].reconfig) program_generator(DIRECTED_ROWS[i].cfg);
         push_tick(DIRECTED_ROWS[i].restart, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].code);
      end

      for (int p = 0; p < 30; p++) begin
         program_generator(random_setting());
         n = $urandom_range(20, 80);
         steady_run = (p >= 12 && p < 16);
         if (p == 3) begin
            n = 120;
            hold_off_armed = 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            push_tick((i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 4),
                      1'b0, 16'h0000);
         end
      end
      steady_run = 1'b0;

      // longest start delay, then longest bit hold, first ticks of each
      cfg = random_setting();
      cfg.mode = MODE_MSEQ;
      cfg.ratio = 16'd0;
      cfg.delay = 16'hFFFF;
      program_generator(cfg);
      for (int i = 0; i < 40; i++) push_tick(i == 0, 1'b0, 16'h0000);
      cfg.ratio = 16'hFFFF;
      cfg.delay = 16'd0;
      program_generator(cfg);
      for (int i = 0; i < 40; i++) push_tick(i == 0, 1'b0, 16'h0000);

      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Ran %0d sample ticks under %0d register settings, all four wave modes,",
               ticks_sent, settings_loaded);
      $display("offset binary on and off, longest start delay and hold; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
